### src/owvpd_pkg.sv
// Shared types and constants for the omni-wheel velocity drive block.
package owvpd_pkg;

  localparam int DATA_W     = 16;
  localparam int COEF_W     = 3 * DATA_W;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int NUM_WHEELS = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL0_COEFFS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL1_COEFFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL2_COEFFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL3_COEFFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd4;

  localparam logic [DATA_W-1:0] GAIN_RESET = 16'd256;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

### src/owvpd_in_if.sv
// Input channel: chassis command and measured wheel speeds.
interface owvpd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [owvpd_pkg::DATA_W-1:0]    yaw_rate_cmd;
  logic signed [owvpd_pkg::DATA_W-1:0]    vel_x_cmd;
  logic signed [owvpd_pkg::DATA_W-1:0]    vel_y_cmd;
  logic signed [owvpd_pkg::DATA_W-1:0]    wheel0_speed;
  logic signed [owvpd_pkg::DATA_W-1:0]    wheel1_speed;
  logic signed [owvpd_pkg::DATA_W-1:0]    wheel2_speed;
  logic signed [owvpd_pkg::DATA_W-1:0]    wheel3_speed;

  modport source (
    output valid, yaw_rate_cmd, vel_x_cmd, vel_y_cmd,
    output wheel0_speed, wheel1_speed, wheel2_speed, wheel3_speed,
    input  ready
  );
  modport sink (
    input  valid, yaw_rate_cmd, vel_x_cmd, vel_y_cmd,
    input  wheel0_speed, wheel1_speed, wheel2_speed, wheel3_speed,
    output ready
  );
endinterface

### src/owvpd_out_if.sv
// Result channel: saturated wheel efforts and clip flags.
interface owvpd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [owvpd_pkg::DATA_W-1:0]     effort0;
  logic signed [owvpd_pkg::DATA_W-1:0]     effort1;
  logic signed [owvpd_pkg::DATA_W-1:0]     effort2;
  logic signed [owvpd_pkg::DATA_W-1:0]     effort3;
  logic        [owvpd_pkg::NUM_WHEELS-1:0] saturated;

  modport source (
    output valid, effort0, effort1, effort2, effort3, saturated,
    input  ready
  );
  modport sink (
    input  valid, effort0, effort1, effort2, effort3, saturated,
    output ready
  );
endinterface

### src/omni_wheel_velocity_p_drive_top.sv
// Top level: omni-wheel command to proportional wheel effort, four-stage pipeline.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        yaw_rate_cmd, vel_x_cmd, vel_y_cmd, wheel0..3_speed
//   out_ch   out  valid/ready        effort0..3, saturated
//   cfg_*    in   cfg_we             cfg_idx, cfg_wdata (coeffs 0..3, prop_gain)
//
// One item per cycle sustained while out_ch.ready is high; each item passes through
// the four register stages (products, sum, gain multiply, clip).
// Reset clears stage valid bits and loads the config registers to their defaults.
// A stage holds while the one after it is full and stalled; bubbles collapse.
module omni_wheel_velocity_p_drive_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  owvpd_in_if.sink                               in_ch,
  owvpd_out_if.source                            out_ch,
  input  logic                                   cfg_we,
  input  logic [owvpd_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [owvpd_pkg::COEF_W-1:0]           cfg_wdata
);

  localparam int NW = owvpd_pkg::NUM_WHEELS;
  localparam int DW = owvpd_pkg::DATA_W;

  logic [owvpd_pkg::COEF_W-1:0] coeffs_r [NW];
  logic [DW-1:0]                gain_r;
  logic                         v1_r, v2_r, v3_r, v4_r;
  owvpd_pkg::stage_en_t         en;
  logic signed [DW-1:0]         speed [NW];
  logic signed [DW-1:0]         effort [NW];
  logic [NW-1:0]                sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) begin
        coeffs_r[i] <= '0;
      end
      gain_r <= owvpd_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        owvpd_pkg::REG_WHEEL0_COEFFS: coeffs_r[0] <= cfg_wdata;
        owvpd_pkg::REG_WHEEL1_COEFFS: coeffs_r[1] <= cfg_wdata;
        owvpd_pkg::REG_WHEEL2_COEFFS: coeffs_r[2] <= cfg_wdata;
        owvpd_pkg::REG_WHEEL3_COEFFS: coeffs_r[3] <= cfg_wdata;
        owvpd_pkg::REG_PROP_GAIN:     gain_r      <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one moves
  always_comb begin
    en.s4 = !v4_r || out_ch.ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_ch.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  assign in_ch.ready = en.s1;

  assign speed[0] = in_ch.wheel0_speed;
  assign speed[1] = in_ch.wheel1_speed;
  assign speed[2] = in_ch.wheel2_speed;
  assign speed[3] = in_ch.wheel3_speed;

  for (genvar w = 0; w < NW; w++) begin : g_lane
    owvpd_wheel_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (en),
      .coeffs (coeffs_r[w]),
      .gain   (gain_r),
      .yaw_cmd(in_ch.yaw_rate_cmd),
      .vx_cmd (in_ch.vel_x_cmd),
      .vy_cmd (in_ch.vel_y_cmd),
      .speed  (speed[w]),
      .effort (effort[w]),
      .sat    (sat[w])
    );
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.effort0   = effort[0];
  assign out_ch.effort1   = effort[1];
  assign out_ch.effort2   = effort[2];
  assign out_ch.effort3   = effort[3];
  assign out_ch.saturated = sat;

endmodule

### src/owvpd_wheel_lane.sv
// Four-stage datapath for one wheel: products, target and error, gain, clip.
module owvpd_wheel_lane #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  owvpd_pkg::stage_en_t                en,
  input  logic        [owvpd_pkg::COEF_W-1:0] coeffs,
  input  logic        [owvpd_pkg::DATA_W-1:0] gain,
  input  logic signed [owvpd_pkg::DATA_W-1:0] yaw_cmd,
  input  logic signed [owvpd_pkg::DATA_W-1:0] vx_cmd,
  input  logic signed [owvpd_pkg::DATA_W-1:0] vy_cmd,
  input  logic signed [owvpd_pkg::DATA_W-1:0] speed,
  output logic signed [owvpd_pkg::DATA_W-1:0] effort,
  output logic                                sat
);

  localparam int DW     = owvpd_pkg::DATA_W;
  localparam int PW     = owvpd_pkg::PROD_W;
  localparam int TW     = PW - FRAC_BITS;
  localparam int DIFF_W = PW + 2 - FRAC_BITS;
  localparam int MW     = DIFF_W + DW + 1;
  localparam int QW     = MW - FRAC_BITS;

  logic signed [PW-1:0]     p_r [3];
  logic signed [DW-1:0]     spd1_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [MW-1:0]     m_r;
  logic signed [DW-1:0]     effort_r;
  logic signed [DW-1:0]     effort_nxt;
  logic                     sat_r;
  logic                     sat_nxt;

  // stage 1: coefficient times command
  always_ff @(posedge clk) begin
    if (en.s1) begin
      p_r[0] <= $signed(coeffs[DW-1:0]) * yaw_cmd;
      p_r[1] <= $signed(coeffs[2*DW-1:DW]) * vx_cmd;
      p_r[2] <= $signed(coeffs[3*DW-1:2*DW]) * vy_cmd;
      spd1_r <= speed;
    end
  end

  // stage 2: truncate toward zero, sum, subtract measured speed
  always_comb begin
    logic signed [PW-1:0] biased;
    logic signed [TW-1:0] t;
    diff_nxt = -DIFF_W'(spd1_r);
    for (int k = 0; k < 3; k++) begin
      biased   = p_r[k] + $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{p_r[k][PW-1]}}});
      t        = biased[PW-1:FRAC_BITS];
      diff_nxt = diff_nxt + DIFF_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      diff_r <= diff_nxt;
    end
  end

  // stage 3: gain times error
  always_ff @(posedge clk) begin
    if (en.s3) begin
      m_r <= $signed({1'b0, gain}) * diff_r;
    end
  end

  // stage 4: truncate toward zero and clip to the output range
  always_comb begin
    logic signed [MW-1:0] biased;
    logic signed [QW-1:0] q;
    biased = m_r + $signed({{(MW-FRAC_BITS){1'b0}}, {FRAC_BITS{m_r[MW-1]}}});
    q      = biased[MW-1:FRAC_BITS];
    sat_nxt = !((&q[QW-1:DW-1]) || !(|q[QW-1:DW-1]));
    if (sat_nxt) begin
      effort_nxt = q[QW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      effort_nxt = q[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      effort_r <= effort_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign effort = effort_r;
  assign sat    = sat_r;

endmodule
